/* design/avralu_pkg.sv */
// avralu_pkg: operation codes, status bit positions and the flag-group
// masks shared by the AVR ALU core and its execution unit.
// No dependencies.
package avralu_pkg;

    // operation codes as carried in the operation field
    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_AND  = 5'd4,
        OP_OR   = 5'd5,
        OP_EOR  = 5'd6,
        OP_COM  = 5'd7,
        OP_NEG  = 5'd8,
        OP_INC  = 5'd9,
        OP_DEC  = 5'd10,
        OP_TST  = 5'd11,
        OP_CLR  = 5'd12,
        OP_SER  = 5'd13,
        OP_CBR  = 5'd14,
        OP_ADIW = 5'd15,
        OP_SBIW = 5'd16
    } op_t;

    localparam int unsigned OP_W     = 5;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned IMM6_W   = 6;

    // status register bit positions
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_V = 3;
    localparam int unsigned FLAG_S = 4;
    localparam int unsigned FLAG_H = 5;

    // flag groups that each class of operation rewrites
    localparam logic [7:0] M_ARITH = 8'b0011_1111;
    localparam logic [7:0] M_LOGIC = 8'b0001_1110;
    localparam logic [7:0] M_WORD  = 8'b0001_1111;
    localparam logic [7:0] M_CARRY = 8'b0000_0001;
    localparam logic [7:0] M_NONE  = 8'b0000_0000;

    // one decoded item as held in the input register
    typedef struct packed {
        op_t        operation;
        logic [7:0] dest_value;
        logic [7:0] source_value;
        logic [7:0] dest_high;
    } alu_item_t;

    // one finished result
    typedef struct packed {
        logic [7:0] status_out;
        logic [7:0] result_high;
        logic [7:0] result_low;
    } alu_result_t;

endpackage

/* design/avralu_exec.sv */
// avralu_exec: combinational execution of one AVR ALU operation,
// producing the result bytes and the next status register value.
// Depends on avralu_pkg.
module avralu_exec (
    input  avralu_pkg::alu_item_t   item,
    input  logic [7:0]              status_in,
    output avralu_pkg::alu_result_t result
);

    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  fl;
    logic [7:0]  mask;
    logic [8:0]  sum9;
    logic [15:0] word_in;
    logic [15:0] word_k;
    logic [15:0] word_r;
    logic        cin;
    logic        d3, s3, r3, d7, s7, r7;
    logic        v_bit, h_bit, c_bit, n_bit, z_bit, h7, r15;
    logic [7:0]  d;
    logic [7:0]  s;

    // operation decode, result and flag computation
    always_comb
    begin
        d       = item.dest_value;
        s       = item.source_value;
        cin     = status_in[avralu_pkg::FLAG_C];
        lo      = d;
        hi      = 8'h00;
        fl      = 8'h00;
        mask    = avralu_pkg::M_NONE;
        sum9    = 9'd0;
        word_in = {item.dest_high, d};
        word_k  = {{(16 - avralu_pkg::IMM6_W){1'b0}}, s[avralu_pkg::IMM6_W-1:0]};
        word_r  = 16'h0000;
        v_bit   = 1'b0;
        h_bit   = 1'b0;
        c_bit   = 1'b0;
        h7      = item.dest_high[7];
        r15     = 1'b0;

        case (item.operation)
            avralu_pkg::OP_ADD, avralu_pkg::OP_ADC:
            begin
                sum9 = {1'b0, d} + {1'b0, s}
                     + {8'd0, (item.operation == avralu_pkg::OP_ADC) & cin};
                lo   = sum9[7:0];
                mask = avralu_pkg::M_ARITH;
            end
            avralu_pkg::OP_SUB, avralu_pkg::OP_SBC:
            begin
                sum9 = {1'b0, d} - {1'b0, s}
                     - {8'd0, (item.operation == avralu_pkg::OP_SBC) & cin};
                lo   = sum9[7:0];
                mask = avralu_pkg::M_ARITH;
            end
            avralu_pkg::OP_AND:
            begin
                lo   = d & s;
                mask = avralu_pkg::M_LOGIC;
            end
            avralu_pkg::OP_OR:
            begin
                lo   = d | s;
                mask = avralu_pkg::M_LOGIC;
            end
            avralu_pkg::OP_EOR:
            begin
                lo   = d ^ s;
                mask = avralu_pkg::M_LOGIC;
            end
            avralu_pkg::OP_COM:
            begin
                lo   = ~d;
                mask = avralu_pkg::M_LOGIC | avralu_pkg::M_CARRY;
            end
            avralu_pkg::OP_NEG:
            begin
                lo   = 8'h00 - d;
                mask = avralu_pkg::M_ARITH;
            end
            avralu_pkg::OP_INC:
            begin
                lo   = d + 8'h01;
                mask = avralu_pkg::M_LOGIC;
            end
            avralu_pkg::OP_DEC:
            begin
                lo   = d - 8'h01;
                mask = avralu_pkg::M_LOGIC;
            end
            avralu_pkg::OP_TST:
            begin
                lo   = d;
                mask = avralu_pkg::M_LOGIC;
            end
            avralu_pkg::OP_CLR:
            begin
                lo   = 8'h00;
                mask = avralu_pkg::M_LOGIC;
            end
            avralu_pkg::OP_SER:
            begin
                lo   = 8'hFF;
                mask = avralu_pkg::M_NONE;
            end
            avralu_pkg::OP_CBR:
            begin
                lo   = d & ~s;
                mask = avralu_pkg::M_LOGIC;
            end
            avralu_pkg::OP_ADIW:
            begin
                word_r = word_in + word_k;
                lo     = word_r[7:0];
                hi     = word_r[15:8];
                mask   = avralu_pkg::M_WORD;
            end
            avralu_pkg::OP_SBIW:
            begin
                word_r = word_in - word_k;
                lo     = word_r[7:0];
                hi     = word_r[15:8];
                mask   = avralu_pkg::M_WORD;
            end
            default:
            begin
                lo   = d;
                mask = avralu_pkg::M_NONE;
            end
        endcase

        d3 = d[3];
        s3 = s[3];
        r3 = lo[3];
        d7 = d[7];
        s7 = s[7];
        r7 = lo[7];
        n_bit = r7;
        z_bit = (lo == 8'h00);

        // carry, half carry and overflow per operation class
        case (item.operation)
            avralu_pkg::OP_ADD, avralu_pkg::OP_ADC:
            begin
                h_bit = (d3 & s3) | (s3 & ~r3) | (~r3 & d3);
                v_bit = (d7 & s7 & ~r7) | (~d7 & ~s7 & r7);
                c_bit = (d7 & s7) | (s7 & ~r7) | (~r7 & d7);
            end
            avralu_pkg::OP_SUB, avralu_pkg::OP_SBC:
            begin
                h_bit = (~d3 & s3) | (s3 & r3) | (r3 & ~d3);
                v_bit = (d7 & ~s7 & ~r7) | (~d7 & s7 & r7);
                c_bit = (~d7 & s7) | (s7 & r7) | (r7 & ~d7);
                // zero chains across a multi-byte subtract with carry
                if (item.operation == avralu_pkg::OP_SBC)
                begin
                    z_bit = z_bit & status_in[avralu_pkg::FLAG_Z];
                end
            end
            avralu_pkg::OP_COM:
            begin
                c_bit = 1'b1;
            end
            avralu_pkg::OP_NEG:
            begin
                h_bit = r3 | d3;
                v_bit = (lo == 8'h80);
                c_bit = (lo != 8'h00);
            end
            avralu_pkg::OP_INC:
            begin
                v_bit = (lo == 8'h80);
            end
            avralu_pkg::OP_DEC:
            begin
                v_bit = (lo == 8'h7F);
            end
            avralu_pkg::OP_ADIW, avralu_pkg::OP_SBIW:
            begin
                r15   = word_r[15];
                n_bit = r15;
                z_bit = (word_r == 16'h0000);
                if (item.operation == avralu_pkg::OP_SBIW)
                begin
                    v_bit = h7 & ~r15;
                    c_bit = r15 & ~h7;
                end
                else
                begin
                    v_bit = ~h7 & r15;
                    c_bit = ~r15 & h7;
                end
            end
            default:
            begin
                v_bit = 1'b0;
            end
        endcase

        fl[avralu_pkg::FLAG_C] = c_bit;
        fl[avralu_pkg::FLAG_Z] = z_bit;
        fl[avralu_pkg::FLAG_N] = n_bit;
        fl[avralu_pkg::FLAG_V] = v_bit;
        fl[avralu_pkg::FLAG_S] = n_bit ^ v_bit;
        fl[avralu_pkg::FLAG_H] = h_bit;

        result.result_low  = lo;
        result.result_high = hi;
        result.status_out  = (status_in & ~mask) | (fl & mask);
    end

endmodule

/* design/avr_alu_with_status_flags_core.sv */
// avr_alu_with_status_flags_core: 8-bit AVR ALU with a kept status register,
// input register, execution unit and result register on stream channels.
// Depends on avralu_pkg and avralu_exec.
//
//  channel | direction | contents
//  --------+-----------+---------------------------------------------------
//  s_axis  | in        | one operation with its operand bytes per item
//  m_axis  | out       | result bytes and updated status, one per item
//
// One item per cycle sustained while the output is not stalled; an accepted
// item is loaded into the input register and then, once the result register
// can take it, into the result register, where its result becomes valid.
// The status register is written in the same cycle as the result register,
// so each item sees the status left by the one before it.
// Reset clears the status register and both valid bits.
// A stalled output holds the result; the input register can still take one
// item while the result register is full, then holds until that drains.
module avr_alu_with_status_flags_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] operation, [12:5] dest_value, [20:13] source_value,
    // [28:21] dest_high, [31:29] zero
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] result_low, [15:8] result_high, [23:16] status_out
    output logic [23:0] m_tdata
);

    avralu_pkg::alu_item_t   item_reg;
    avralu_pkg::alu_item_t   item_next;
    logic                    item_valid_reg;
    avralu_pkg::alu_result_t result_reg;
    avralu_pkg::alu_result_t exec_result;
    logic                    result_valid_reg;
    logic [7:0]              status_reg;
    logic                    advance;
    logic                    in_fire;

    // handshake and field unpacking
    assign advance  = item_valid_reg & (~result_valid_reg | m_tready);
    assign s_tready = ~item_valid_reg | advance;
    assign in_fire  = s_tvalid & s_tready;

    always_comb
    begin
        item_next.operation    = avralu_pkg::op_t'(s_tdata[4:0]);
        item_next.dest_value   = s_tdata[12:5];
        item_next.source_value = s_tdata[20:13];
        item_next.dest_high    = s_tdata[28:21];
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= item_next;
        end
    end

    // execution unit
    avralu_exec u_exec (
        .item      (item_reg),
        .status_in (status_reg),
        .result    (exec_result)
    );

    // result register and kept status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            status_reg       <= 8'h00;
        end
        else
        begin
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                status_reg       <= exec_result.status_out;
            end
            else if (m_tready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= exec_result;
        end
    end

    assign m_tvalid = result_valid_reg;
    assign m_tdata  = result_reg;

    // status only moves when an item reaches the result register
    a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(status_reg))
        else $error("status changed while result stalled");

    // reported status matches the kept status
    a_status_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:16] == status_reg))
        else $error("output status differs from status register");

    // upper status bits are never set
    a_status_upper: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[7:6] == 2'b00)
        else $error("unused status bits set");

    // an executed item always shows up as a valid result
    a_advance_valid: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("executed item lost");

endmodule
